// ===== rtl/osp_pkg.sv =====
// Shared types, codes and constants of the object id server placement block.
package osp_pkg;

   localparam int MAX_STRIPE   = 64;
   localparam int ID_W         = 64;
   localparam int SRV_W        = 16;
   localparam int SERVER_W     = 17;
   localparam int STRIPE_W     = 7;
   localparam int STATUS_W     = 2;
   localparam int KIND_W       = 2;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 16;
   localparam int IDX_W        = $clog2(MAX_STRIPE);
   localparam int DIV_STEPS    = ID_W;
   localparam int DIV_CNT_W    = $clog2(DIV_STEPS + 1);
   localparam int PART_W       = 32 + SRV_W;

   localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

   // placement codes
   localparam logic [KIND_W-1:0] KIND_ZERO = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MOD  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RNG  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_KIND     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SERVER_COUNT = 2'd1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd2;

   localparam logic MODE_LOOKUP   = 1'b0;
   localparam logic MODE_GENERATE = 1'b1;

   typedef struct packed {
      logic                mode;
      logic [ID_W-1:0]     object_id;
      logic [SRV_W-1:0]    first_server;
      logic [SRV_W-1:0]    end_server;
      logic [STRIPE_W-1:0] stripe_count;
   } req_type;

   typedef struct packed {
      logic [SERVER_W-1:0] server;
      logic [ID_W-1:0]     generated_id;
      logic [STATUS_W-1:0] status;
      logic                last;
   } rsp_type;

   // how a request is served; also selects the form of an emitted result
   typedef enum logic [2:0] {
      PLAN_ERR_ZERO,
      PLAN_ERR_RANGE,
      PLAN_OK_NONE,
      PLAN_LK_MOD,
      PLAN_LK_RNG,
      PLAN_GEN_MOD,
      PLAN_GEN_RNG
   } plan_type;

   typedef enum logic [1:0] {
      DIV_LK_MOD,
      DIV_WIDTH,
      DIV_LK_RNG,
      DIV_STRIPE
   } div_op_type;

   typedef enum logic [1:0] {
      MUL_FIRST,
      MUL_END,
      MUL_T
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        div_start;
      div_op_type  div_op;
      logic        cap_w;
      logic        mul_lo;
      logic        mul_hi;
      mul_sel_type mul_sel;
      logic        cap_lb;
      logic        cap_len;
      logic        idx_inc;
      logic        emit;
      plan_type    emit_kind;
      logic        emit_last;
   } cmd_type;

   typedef struct packed {
      plan_type plan;
      logic     div_done;
      logic     idx_last;
   } stat_type;

endpackage

// ===== rtl/osp_divider.sv =====
// Restoring 64-bit unsigned divider, one quotient bit per cycle.
module osp_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [osp_pkg::ID_W-1:0]  dividend,
   input  logic [osp_pkg::ID_W-1:0]  divisor,
   output logic                      done,
   output logic [osp_pkg::ID_W-1:0]  quotient,
   output logic [osp_pkg::ID_W-1:0]  remainder
);

   logic [osp_pkg::ID_W-1:0]      quo_ff, quo_in;
   logic [osp_pkg::ID_W-1:0]      rem_ff, rem_in;
   logic [osp_pkg::ID_W-1:0]      dsr_ff, dsr_in;
   logic [osp_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          done_ff, done_in;
   logic [osp_pkg::ID_W:0]        shifted;
   logic [osp_pkg::ID_W:0]        diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[osp_pkg::ID_W-1]};
      diff    = shifted - {1'b0, dsr_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = osp_pkg::DIV_CNT_W'(osp_pkg::DIV_STEPS);
      end else if (cnt_ff != '0) begin
         // subtract when the shifted partial remainder covers the divisor
         if (!diff[osp_pkg::ID_W]) begin
            rem_in = diff[osp_pkg::ID_W-1:0];
            quo_in = {quo_ff[osp_pkg::ID_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[osp_pkg::ID_W-1:0];
            quo_in = {quo_ff[osp_pkg::ID_W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == osp_pkg::DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/osp_datapath.sv =====
// Datapath: registers, request decode, divider, split multiplier and result register.
module osp_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  osp_pkg::req_type                req_data,
   input  logic                            csr_we,
   input  logic [osp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [osp_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  osp_pkg::cmd_type                cmd,
   output osp_pkg::stat_type               stat,
   output logic                            rsp_valid,
   output osp_pkg::rsp_type                rsp_data
);

   logic [osp_pkg::KIND_W-1:0]   kind_ff;
   logic [osp_pkg::SRV_W-1:0]    count_ff;
   osp_pkg::req_type             req_ff;
   logic [osp_pkg::IDX_W-1:0]    idx_ff;
   logic [osp_pkg::ID_W-1:0]     w_ff;
   logic [osp_pkg::ID_W-1:0]     lb_ff;
   logic [osp_pkg::ID_W-1:0]     len_ff;
   logic [osp_pkg::PART_W-1:0]   part_ff;
   logic [osp_pkg::ID_W-1:0]     prod_ff;
   logic                         rsp_valid_ff;
   osp_pkg::rsp_type             rsp_data_ff, rsp_data_in;

   logic                         spread;
   logic [osp_pkg::SRV_W-1:0]    span;
   osp_pkg::plan_type            plan;
   logic [osp_pkg::SRV_W-1:0]    t_srv;
   logic [osp_pkg::SRV_W-1:0]    mul_op;
   logic [osp_pkg::PART_W-1:0]   hi_prod;
   logic [osp_pkg::ID_W-1:0]     ub;
   logic [osp_pkg::ID_W-1:0]     div_a, div_b;
   logic                         div_done;
   logic [osp_pkg::ID_W-1:0]     div_quo, div_rem;

   // decode the live request against the configuration
   always_comb begin
      spread = (kind_ff == osp_pkg::KIND_MOD) || (kind_ff == osp_pkg::KIND_RNG);
      span   = req_data.end_server - req_data.first_server;
      if (spread && count_ff == '0) begin
         plan = osp_pkg::PLAN_ERR_ZERO;
      end else if (req_data.mode == osp_pkg::MODE_LOOKUP) begin
         if (kind_ff == osp_pkg::KIND_MOD)      plan = osp_pkg::PLAN_LK_MOD;
         else if (kind_ff == osp_pkg::KIND_RNG) plan = osp_pkg::PLAN_LK_RNG;
         else                                   plan = osp_pkg::PLAN_OK_NONE;
      end else if (req_data.end_server <= req_data.first_server) begin
         plan = osp_pkg::PLAN_ERR_RANGE;
      end else if (span < osp_pkg::SRV_W'(req_data.stripe_count) || span > count_ff
                   || req_data.stripe_count == '0
                   || req_data.stripe_count > osp_pkg::STRIPE_W'(osp_pkg::MAX_STRIPE)) begin
         plan = osp_pkg::PLAN_ERR_RANGE;
      end else if (!spread) begin
         plan = (span > osp_pkg::SRV_W'(1)) ? osp_pkg::PLAN_ERR_RANGE
                                            : osp_pkg::PLAN_OK_NONE;
      end else if (kind_ff == osp_pkg::KIND_RNG && req_data.end_server > count_ff) begin
         plan = osp_pkg::PLAN_ERR_RANGE;
      end else if (kind_ff == osp_pkg::KIND_MOD) begin
         plan = osp_pkg::PLAN_GEN_MOD;
      end else begin
         plan = osp_pkg::PLAN_GEN_RNG;
      end
   end

   assign t_srv = req_ff.first_server + osp_pkg::SRV_W'(idx_ff);

   always_comb begin
      case (cmd.mul_sel)
         osp_pkg::MUL_FIRST: mul_op = req_ff.first_server;
         osp_pkg::MUL_END:   mul_op = req_ff.end_server;
         osp_pkg::MUL_T:     mul_op = t_srv;
         default:            mul_op = '0;
      endcase
   end

   assign hi_prod = w_ff[63:32] * mul_op;
   assign ub      = (req_ff.end_server == count_ff) ? osp_pkg::ID_MAX : prod_ff;

   always_comb begin
      case (cmd.div_op)
         osp_pkg::DIV_LK_MOD: begin
            div_a = req_ff.object_id;
            div_b = osp_pkg::ID_W'(count_ff);
         end
         osp_pkg::DIV_WIDTH: begin
            div_a = osp_pkg::ID_MAX;
            div_b = osp_pkg::ID_W'(count_ff);
         end
         osp_pkg::DIV_LK_RNG: begin
            div_a = req_ff.object_id;
            div_b = w_ff;
         end
         osp_pkg::DIV_STRIPE: begin
            div_a = prod_ff;
            div_b = len_ff;
         end
         default: begin
            div_a = '0;
            div_b = '0;
         end
      endcase
   end

   osp_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      rsp_data_in              = '0;
      rsp_data_in.last         = cmd.emit_last;
      case (cmd.emit_kind)
         osp_pkg::PLAN_ERR_ZERO:  rsp_data_in.status = osp_pkg::ST_ZERO;
         osp_pkg::PLAN_ERR_RANGE: rsp_data_in.status = osp_pkg::ST_RANGE;
         osp_pkg::PLAN_OK_NONE:   rsp_data_in.status = osp_pkg::ST_OK;
         osp_pkg::PLAN_LK_MOD:    rsp_data_in.server = div_rem[osp_pkg::SERVER_W-1:0];
         osp_pkg::PLAN_LK_RNG:    rsp_data_in.server = div_quo[osp_pkg::SERVER_W-1:0];
         osp_pkg::PLAN_GEN_MOD:   rsp_data_in.generated_id = osp_pkg::ID_W'(t_srv);
         osp_pkg::PLAN_GEN_RNG:   rsp_data_in.generated_id = div_rem + lb_ff;
         default:                 rsp_data_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff      <= osp_pkg::KIND_ZERO;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we && csr_index == osp_pkg::CSR_MAP_KIND)
            kind_ff <= csr_wdata[osp_pkg::KIND_W-1:0];
         if (csr_we && csr_index == osp_pkg::CSR_SERVER_COUNT)
            count_ff <= csr_wdata[osp_pkg::SRV_W-1:0];
         if (cmd.load)          idx_ff <= '0;
         else if (cmd.idx_inc)  idx_ff <= idx_ff + 1'b1;
         rsp_valid_ff <= cmd.emit;
      end
      if (cmd.load)    req_ff  <= req_data;
      if (cmd.cap_w)   w_ff    <= div_quo;
      if (cmd.mul_lo)  part_ff <= w_ff[31:0] * mul_op;
      if (cmd.mul_hi)  prod_ff <= osp_pkg::ID_W'(part_ff) + {hi_prod[31:0], 32'b0};
      if (cmd.cap_lb)  lb_ff   <= prod_ff;
      if (cmd.cap_len) len_ff  <= ub - lb_ff;
      if (cmd.emit)    rsp_data_ff <= rsp_data_in;
   end

   assign stat.plan     = plan;
   assign stat.div_done = div_done;
   assign stat.idx_last = (osp_pkg::STRIPE_W'(idx_ff) + 1'b1) == req_ff.stripe_count;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/osp_ctrl.sv =====
// Controller: sequences divides, multiplies and result emission per request.
module osp_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  osp_pkg::stat_type  stat,
   output logic               busy,
   output osp_pkg::cmd_type   cmd
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_ONE,
      S_LKM_DIV,
      S_LKM_WAIT,
      S_W_DIV,
      S_W_WAIT,
      S_LKR_DIV,
      S_LKR_WAIT,
      S_LB_LO,
      S_LB_HI,
      S_UB_LO,
      S_UB_HI,
      S_LEN,
      S_R_LO,
      S_R_HI,
      S_R_DIV,
      S_R_WAIT,
      S_R_EMIT,
      S_GM_EMIT
   } state_type;

   state_type         state_ff, state_in;
   osp_pkg::plan_type plan_ff, plan_in;

   always_comb begin
      state_in          = state_ff;
      plan_in           = plan_ff;
      cmd.load          = 1'b0;
      cmd.div_start     = 1'b0;
      cmd.div_op        = osp_pkg::DIV_LK_MOD;
      cmd.cap_w         = 1'b0;
      cmd.mul_lo        = 1'b0;
      cmd.mul_hi        = 1'b0;
      cmd.mul_sel       = osp_pkg::MUL_FIRST;
      cmd.cap_lb        = 1'b0;
      cmd.cap_len       = 1'b0;
      cmd.idx_inc       = 1'b0;
      cmd.emit          = 1'b0;
      cmd.emit_kind     = plan_ff;
      cmd.emit_last     = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               plan_in  = stat.plan;
               case (stat.plan)
                  osp_pkg::PLAN_LK_MOD:  state_in = S_LKM_DIV;
                  osp_pkg::PLAN_LK_RNG:  state_in = S_W_DIV;
                  osp_pkg::PLAN_GEN_RNG: state_in = S_W_DIV;
                  osp_pkg::PLAN_GEN_MOD: state_in = S_GM_EMIT;
                  default:               state_in = S_ONE;
               endcase
            end
         end
         S_ONE: begin
            cmd.emit = 1'b1;
            state_in = S_IDLE;
         end
         S_LKM_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = osp_pkg::DIV_LK_MOD;
            state_in      = S_LKM_WAIT;
         end
         S_LKM_WAIT: begin
            if (stat.div_done) state_in = S_ONE;
         end
         S_W_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = osp_pkg::DIV_WIDTH;
            state_in      = S_W_WAIT;
         end
         S_W_WAIT: begin
            if (stat.div_done) begin
               cmd.cap_w = 1'b1;
               state_in  = (plan_ff == osp_pkg::PLAN_LK_RNG) ? S_LKR_DIV : S_LB_LO;
            end
         end
         S_LKR_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = osp_pkg::DIV_LK_RNG;
            state_in      = S_LKR_WAIT;
         end
         S_LKR_WAIT: begin
            if (stat.div_done) state_in = S_ONE;
         end
         S_LB_LO: begin
            cmd.mul_lo  = 1'b1;
            cmd.mul_sel = osp_pkg::MUL_FIRST;
            state_in    = S_LB_HI;
         end
         S_LB_HI: begin
            cmd.mul_hi  = 1'b1;
            cmd.mul_sel = osp_pkg::MUL_FIRST;
            state_in    = S_UB_LO;
         end
         S_UB_LO: begin
            cmd.cap_lb  = 1'b1;
            cmd.mul_lo  = 1'b1;
            cmd.mul_sel = osp_pkg::MUL_END;
            state_in    = S_UB_HI;
         end
         S_UB_HI: begin
            cmd.mul_hi  = 1'b1;
            cmd.mul_sel = osp_pkg::MUL_END;
            state_in    = S_LEN;
         end
         S_LEN: begin
            cmd.cap_len = 1'b1;
            state_in    = S_R_LO;
         end
         S_R_LO: begin
            cmd.mul_lo  = 1'b1;
            cmd.mul_sel = osp_pkg::MUL_T;
            state_in    = S_R_HI;
         end
         S_R_HI: begin
            cmd.mul_hi  = 1'b1;
            cmd.mul_sel = osp_pkg::MUL_T;
            state_in    = S_R_DIV;
         end
         S_R_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = osp_pkg::DIV_STRIPE;
            state_in      = S_R_WAIT;
         end
         S_R_WAIT: begin
            if (stat.div_done) state_in = S_R_EMIT;
         end
         S_R_EMIT: begin
            cmd.emit      = 1'b1;
            cmd.emit_last = stat.idx_last;
            cmd.idx_inc   = 1'b1;
            state_in      = stat.idx_last ? S_IDLE : S_R_LO;
         end
         S_GM_EMIT: begin
            cmd.emit      = 1'b1;
            cmd.emit_last = stat.idx_last;
            cmd.idx_inc   = 1'b1;
            if (stat.idx_last) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         plan_ff  <= osp_pkg::PLAN_OK_NONE;
      end else begin
         state_ff <= state_in;
         plan_ff  <= plan_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ===== rtl/object_id_server_placement.sv =====
// Top level: object id to storage server placement, lookup and striped id generation.
// Per plan: lookup under modulo takes one divide, lookup under ranges two (the width,
//   then the id); errors and trivial results take no divide; generate under modulo
//   emits one result a cycle; generate under ranges divides for the width, then
//   multiplies and divides once per result. One request at a time; the next is
//   taken at the edge that ends the last result's cycle; each divide is 64 steps.
// Results leave on rsp_valid for one cycle each and cannot be stalled.
// Reset: synchronous, clears control state and sets map_kind and server_count to 0.
module object_id_server_placement (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            start,
   output logic                            busy,
   input  osp_pkg::req_type                req_data,
   // result channel
   output logic                            rsp_valid,
   output osp_pkg::rsp_type                rsp_data,
   // configuration writes
   input  logic                            csr_we,
   input  logic [osp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [osp_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // Commands flow from the controller, status flows back; nothing else couples them.
   osp_pkg::cmd_type  cmd;
   osp_pkg::stat_type stat;

   // Sequence each request: pick a plan at accept, then step the divider and
   // multiplier, and drop one result per striped server (one only for a lookup or an error) into the result register.
   osp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   // Hold configuration, the latched request, width, bounds and the result register.
   osp_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/sv/object_id_server_placement_test.sv =====
// Self-checking testbench of the object id server placement block.
module object_id_server_placement_test;
   timeunit 1ns;
   timeprecision 1ps;

   import osp_pkg::*;

   // map_kind 3 is not a placement of its own; the block treats it as all on zero
   localparam logic [KIND_W-1:0]    KIND_UNUSED  = 2'd3;
   // register indexes past server_count; writes there must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B  = 2'd3;
   // slowest quiet stretch: a range lookup, or the first striped id under ranges;
   // take it many times over to absorb sender gaps and the end wait
   localparam int                   QUIET_LIMIT  = 20000;
   localparam int                   TAIL_CYCLES  = 200;
   localparam int                   PHASE_ITEMS  = 29;

   typedef struct {
      logic [KIND_W-1:0]   kind;
      logic [SRV_W-1:0]    count;
      logic                mode;
      logic [ID_W-1:0]     object_id;
      logic [SRV_W-1:0]    first_srv;
      logic [SRV_W-1:0]    end_srv;
      logic [STRIPE_W-1:0] stripe;
      bit                  typed;         // use the typed-in result below
      logic [SERVER_W-1:0] want_server;
      logic [STATUS_W-1:0] want_status;
   } stim_row_type;

   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [SRV_W-1:0]  count;
      int                idle_pct;        // chance in 100 of a sender gap cycle
   } phase_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // placement settings as the block should hold them
   logic [KIND_W-1:0] cfg_kind;
   logic [SRV_W-1:0]  cfg_count;

   rsp_type awaited_placements[$];
   int      error_count  = 0;
   int      quiet_cycles = 0;

   // Directed part: extremes, every operation, every error path.
   // Results that are obvious are typed in; the rest go through the predictor.
   stim_row_type directed_rows[23] = '{
      // after reset: all on server zero, no servers
      '{KIND_ZERO, 16'd0, MODE_LOOKUP, ID_MAX, 16'd0, 16'd0, 7'd0,
        1'b1, 17'd0, ST_OK},
      '{KIND_ZERO, 16'd0, MODE_GENERATE, 64'd0, 16'd0, 16'd1, 7'd1,
        1'b1, 17'd0, ST_RANGE},
      // all on zero: one-server range is fine, two is not
      '{KIND_ZERO, 16'd4, MODE_GENERATE, 64'd0, 16'd2, 16'd3, 7'd1,
        1'b1, 17'd0, ST_OK},
      '{KIND_ZERO, 16'd4, MODE_GENERATE, 64'd0, 16'd2, 16'd4, 7'd1,
        1'b1, 17'd0, ST_RANGE},
      // zero server count under the spreading placements
      '{KIND_MOD, 16'd0, MODE_LOOKUP, 64'd77, 16'd0, 16'd0, 7'd0,
        1'b1, 17'd0, ST_ZERO},
      '{KIND_MOD, 16'd0, MODE_GENERATE, 64'd0, 16'd65535, 16'd0, 7'd127,
        1'b1, 17'd0, ST_ZERO},
      '{KIND_RNG, 16'd0, MODE_LOOKUP, ID_MAX, 16'd0, 16'd0, 7'd0,
        1'b1, 17'd0, ST_ZERO},
      // modulo at the widest server count
      '{KIND_MOD, 16'd65535, MODE_LOOKUP, ID_MAX, 16'd0, 16'd0, 7'd0,
        1'b0, 17'd0, ST_OK},
      '{KIND_MOD, 16'd65535, MODE_LOOKUP, 64'd0, 16'd0, 16'd0, 7'd0,
        1'b1, 17'd0, ST_OK},
      '{KIND_MOD, 16'd65535, MODE_GENERATE, 64'd0, 16'd65471, 16'd65535, 7'd64,
        1'b0, 17'd0, ST_OK},
      '{KIND_MOD, 16'd65535, MODE_GENERATE, 64'd0, 16'd65535, 16'd0, 7'd1,
        1'b1, 17'd0, ST_RANGE},
      // empty stripe, overlong stripe, stripe longer than the range
      '{KIND_MOD, 16'd65535, MODE_GENERATE, 64'd0, 16'd0, 16'd10, 7'd0,
        1'b1, 17'd0, ST_RANGE},
      '{KIND_MOD, 16'd65535, MODE_GENERATE, 64'd0, 16'd0, 16'd200, 7'd127,
        1'b1, 17'd0, ST_RANGE},
      '{KIND_MOD, 16'd65535, MODE_GENERATE, 64'd0, 16'd0, 16'd5, 7'd6,
        1'b1, 17'd0, ST_RANGE},
      // equal ranges, widest count; the top range ends at the id maximum
      '{KIND_RNG, 16'd65535, MODE_LOOKUP, ID_MAX, 16'd0, 16'd0, 7'd0,
        1'b0, 17'd0, ST_OK},
      '{KIND_RNG, 16'd65535, MODE_LOOKUP, 64'd0, 16'd0, 16'd0, 7'd0,
        1'b1, 17'd0, ST_OK},
      '{KIND_RNG, 16'd65535, MODE_GENERATE, 64'd0, 16'd65533, 16'd65535, 7'd2,
        1'b0, 17'd0, ST_OK},
      // range past the servers, then a plain striped range
      '{KIND_RNG, 16'd100, MODE_GENERATE, 64'd0, 16'd90, 16'd110, 7'd3,
        1'b1, 17'd0, ST_RANGE},
      '{KIND_RNG, 16'd100, MODE_GENERATE, 64'd0, 16'd10, 16'd20, 7'd4,
        1'b0, 17'd0, ST_OK},
      // range wider than the server count
      '{KIND_MOD, 16'd3, MODE_GENERATE, 64'd0, 16'd0, 16'd5, 7'd1,
        1'b1, 17'd0, ST_RANGE},
      // unused placement code acts as all on zero
      '{KIND_UNUSED, 16'd9, MODE_LOOKUP, 64'd12345, 16'd0, 16'd0, 7'd0,
        1'b1, 17'd0, ST_OK},
      '{KIND_UNUSED, 16'd9, MODE_GENERATE, 64'd0, 16'd4, 16'd5, 7'd1,
        1'b1, 17'd0, ST_OK},
      // a single server; the id maximum still looks up to server 1, past it
      '{KIND_RNG, 16'd1, MODE_LOOKUP, ID_MAX, 16'd0, 16'd0, 7'd0,
        1'b0, 17'd0, ST_OK}
   };

   // Random part: one setting per phase, with its own sender idling.
   phase_type random_phases[9] = '{
      '{KIND_MOD,    16'd7,     0},
      '{KIND_RNG,    16'd5,     84},
      '{KIND_MOD,    16'd65535, 12},
      '{KIND_RNG,    16'd65535, 0},
      '{KIND_UNUSED, 16'd3,     84},
      '{KIND_RNG,    16'd300,   12},
      '{KIND_ZERO,   16'd65535, 0},
      '{KIND_MOD,    16'd1,     84},
      '{KIND_RNG,    16'd1,     12}
   };

   object_id_server_placement i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic void queue_placement(input logic [SERVER_W-1:0] server,
                                           input logic [ID_W-1:0] id,
                                           input logic [STATUS_W-1:0] status,
                                           input logic last);
      rsp_type r;
      r.server       = server;
      r.generated_id = id;
      r.status       = status;
      r.last         = last;
      awaited_placements.push_back(r);
   endfunction

   // Work out every result one request causes under the current placement.
   function automatic void predict_placement(input req_type r);
      logic [ID_W-1:0] n, first, last_srv, stripe, span, width;
      logic [ID_W-1:0] t, cap, base, lb, ub, len, prod, id;
      logic            spread;
      n        = ID_W'(cfg_count);
      first    = ID_W'(r.first_server);
      last_srv = ID_W'(r.end_server);
      stripe   = ID_W'(r.stripe_count);
      spread   = (cfg_kind == KIND_MOD) || (cfg_kind == KIND_RNG);

      // zero count beats every other check
      if (spread && n == 0) begin
         queue_placement('0, '0, ST_ZERO, 1'b1);
         return;
      end
      if (r.mode == MODE_LOOKUP) begin
         if (cfg_kind == KIND_MOD)
            queue_placement(SERVER_W'(r.object_id % n), '0, ST_OK, 1'b1);
         else if (cfg_kind == KIND_RNG)
            queue_placement(SERVER_W'(r.object_id / (ID_MAX / n)), '0, ST_OK, 1'b1);
         else
            queue_placement('0, '0, ST_OK, 1'b1);
         return;
      end
      if (last_srv <= first) begin
         queue_placement('0, '0, ST_RANGE, 1'b1);
         return;
      end
      span = last_srv - first;
      if (span < stripe || span > n || stripe == 0 || stripe > MAX_STRIPE) begin
         queue_placement('0, '0, ST_RANGE, 1'b1);
         return;
      end
      if (!spread) begin
         queue_placement('0, '0, (span > 1) ? ST_RANGE : ST_OK, 1'b1);
         return;
      end
      if (cfg_kind == KIND_RNG && last_srv > n) begin
         queue_placement('0, '0, ST_RANGE, 1'b1);
         return;
      end

      width = ID_MAX / n;
      for (int i = 0; i < int'(stripe); i++) begin
         t = first + ID_W'(i);
         if (cfg_kind == KIND_MOD) begin
            cap  = ID_MAX - last_srv;
            base = (t > cap) ? cap : t;
            id   = base - (base % n) + (t % n);
         end else begin
            lb   = width * first;
            ub   = (last_srv == n) ? ID_MAX : width * last_srv;
            len  = ub - lb;
            prod = t * width;
            id   = ((len != 0) ? prod % len : prod) + lb;
         end
         queue_placement('0, id, ST_OK, (i + 1 == int'(stripe)));
      end
   endfunction

   // Build one random request: lookups, well-formed stripes and raw noise.
   function automatic req_type make_request();
      req_type r;
      int      n, pick, max_span, stripe, span, limit, first;
      logic    spread;
      r.mode         = MODE_LOOKUP;
      r.object_id    = {$urandom, $urandom};
      r.first_server = SRV_W'($urandom);
      r.end_server   = SRV_W'($urandom);
      r.stripe_count = STRIPE_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 8)
         r.object_id = ID_MAX;
      else if (pick < 14)
         r.object_id = '0;

      n      = int'(cfg_count);
      spread = (cfg_kind == KIND_MOD) || (cfg_kind == KIND_RNG);
      pick   = $urandom_range(0, 99);
      if (pick < 42)
         return r;
      r.mode = MODE_GENERATE;
      // keep the random range fields as noise now and then
      if (pick >= 85 || n == 0)
         return r;

      // well-formed stripe: mostly short, now and then up to the full 64
      max_span = spread ? n : 1;
      if ($urandom_range(0, 11) == 0)
         stripe = $urandom_range(1, (max_span < MAX_STRIPE) ? max_span : MAX_STRIPE);
      else
         stripe = $urandom_range(1, (max_span < 4) ? max_span : 4);
      span  = stripe + $urandom_range(0, (max_span - stripe < 3) ? max_span - stripe : 3);
      limit = (cfg_kind == KIND_RNG) ? n : 65535;
      first = $urandom_range(0, limit - span);
      r.first_server = SRV_W'(first);
      r.end_server   = SRV_W'(first + span);
      r.stripe_count = STRIPE_W'(stripe);
      return r;
   endfunction

   // Write one register; call at a falling edge with the block idle.
   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = data;
      @(posedge clock);
      if (index == CSR_MAP_KIND)
         cfg_kind = data[KIND_W-1:0];
      else if (index == CSR_SERVER_COUNT)
         cfg_count = data;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Hold off new requests until every awaited result is in and busy drops.
   task automatic wait_for_drain();
      start = 1'b0;
      while (awaited_placements.size() != 0 || busy)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_placement(input logic [KIND_W-1:0] kind,
                                input logic [SRV_W-1:0] count);
      wait_for_drain();
      // fill the spare upper bits of map_kind with junk; the block must drop them
      write_register(CSR_MAP_KIND, {(CSR_DATA_W - KIND_W)'($urandom), kind});
      write_register(CSR_SERVER_COUNT, count);
   endtask

   // Offer one request at a falling edge and hold it until the block takes it.
   task automatic send_request(input req_type r, input bit typed, input rsp_type typed_rsp);
      req_data = r;
      start    = 1'b1;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      if (typed)
         awaited_placements.push_back(typed_rsp);
      else
         predict_placement(r);
      @(negedge clock);
   endtask

   // Check every result against the oldest awaited one, field by field.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (awaited_placements.size() == 0) begin
            report_mismatch($sformatf("result with nothing awaited: %p", rsp_data));
         end else begin
            want = awaited_placements.pop_front();
            if (rsp_data.server !== want.server)
               report_mismatch($sformatf("server %0d, want %0d",
                                         rsp_data.server, want.server));
            if (rsp_data.generated_id !== want.generated_id)
               report_mismatch($sformatf("generated_id %h, want %h",
                                         rsp_data.generated_id, want.generated_id));
            if (rsp_data.status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d",
                                         rsp_data.status, want.status));
            if (rsp_data.last !== want.last)
               report_mismatch($sformatf("last %0b, want %0b",
                                         rsp_data.last, want.last));
         end
      end
   end

   // Watchdog: end the run after too long with no request, result or write.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("object_id_server_placement_test: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      req_type r;
      rsp_type typed_rsp;
      int      idle_pct;

      // drive every input to a known value before the first edge
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = CSR_MAP_KIND;
      csr_wdata = '0;
      cfg_kind  = KIND_ZERO;
      cfg_count = '0;
      typed_rsp = '0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // writes to the spare indexes must leave the reset placement alone
      write_register(CSR_SPARE_A, '1);
      write_register(CSR_SPARE_B, 16'h5a5a);

      // walk the directed table; change the placement only between drained phases
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind != cfg_kind || directed_rows[i].count != cfg_count)
            set_placement(directed_rows[i].kind, directed_rows[i].count);
         r.mode                 = directed_rows[i].mode;
         r.object_id            = directed_rows[i].object_id;
         r.first_server         = directed_rows[i].first_srv;
         r.end_server           = directed_rows[i].end_srv;
         r.stripe_count         = directed_rows[i].stripe;
         typed_rsp.server       = directed_rows[i].want_server;
         typed_rsp.generated_id = '0;
         typed_rsp.status       = directed_rows[i].want_status;
         typed_rsp.last         = 1'b1;
         send_request(r, directed_rows[i].typed, typed_rsp);
      end

      // random phases, each with its own placement and sender idling
      foreach (random_phases[p]) begin
         set_placement(random_phases[p].kind, random_phases[p].count);
         idle_pct = random_phases[p].idle_pct;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // now and then hold the sender until the block has gone quiet
            if ($urandom_range(0, 24) == 0) begin
               wait_for_drain();
            end else begin
               while ($urandom_range(0, 99) < idle_pct) begin
                  start = 1'b0;
                  @(negedge clock);
               end
            end
            send_request(make_request(), 1'b0, typed_rsp);
         end
      end

      // drain, then give the block time to show any stray result
      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("object_id_server_placement_test: done, clean");
      else
         $display("object_id_server_placement_test: done, errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/osp_pkg.sv
rtl/osp_divider.sv
rtl/osp_datapath.sv
rtl/osp_ctrl.sv
rtl/object_id_server_placement.sv
tb/sv/object_id_server_placement_test.sv
